>>> src/mhpq_pkg.sv
// Package: sizes, codes, entry and state types of the min-heap priority queue.
`default_nettype none
package mhpq_pkg;
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = IDX_W + 1;
   localparam int KEY_W    = 32;
   localparam int IN_IDX_W = 6;
   localparam int CMP_W    = CNT_W + IN_IDX_W;
   localparam int MAX_RES  = 64;
   localparam int BUF_AW   = $clog2(MAX_RES);
   localparam int NRES_W   = BUF_AW + 1;
   localparam int ENTRY_W  = 2 * KEY_W;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_EXTRACT = 2'd1,
      OP_LIST    = 2'd2,
      OP_SET_KEY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic signed [KEY_W-1:0] value;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_SU_RD, S_SU_CMP, S_SK_VAL, S_EX_MIN, S_EX_CHK, S_EX_LAST,
      S_EX_RD, S_SD_RL, S_SD_L, S_SD_R, S_SD_DEC, S_LS_MIN, S_LS_RD,
      S_LS_CMP, S_DR_RD, S_DR_OUT
   } state_type;
endpackage
`default_nettype wire

>>> src/mhpq_if.sv
// Interfaces: request and response channels of the min-heap priority queue.
`default_nettype none
interface mhpq_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           op;
   logic signed [31:0]   key;
   logic signed [31:0]   value;
   logic [5:0]           index;
   modport source (output valid, op, key, value, index, input ready);
   modport sink   (input valid, op, key, value, index, output ready);
endinterface

interface mhpq_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [31:0]   key_res;
   logic signed [31:0]   value_res;
   logic [1:0]           status;
   logic                 last;
   logic [6:0]           count;
   modport source (output valid, key_res, value_res, status, last, count, input ready);
   modport sink   (input valid, key_res, value_res, status, last, count, output ready);
endinterface
`default_nettype wire

>>> src/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mhpq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

>>> src/min_heap_priority_queue_core.sv
// Top level: min-heap priority queue with a sequenced heap RAM and result buffer.
//
// Usage: one request word on req_ch carries op, key, value and index; it is
// accepted when valid and ready are high at a clock edge. ready is high only
// while the block is idle. Each request yields one or more response words on
// rsp_ch; last marks the final one and count gives the entries held after
// the whole operation.
// Sequencing: insert and set-key walk up to log2(CAPACITY) levels, each a
// parent read then a compare and write; extract walks down up to
// log2(CAPACITY) levels per popped entry, each a read of the left and then
// the right child and a write; list reads every held entry. All results go
// to a result buffer first and then drain word by word, each a buffer read
// then an output word. The heap RAM has a single read port, so reads run in turn.
// Reset empties the heap at once; no clearing pass runs.
// When the receiver stalls, the current response word holds and the block
// takes no new request until the last word is taken.
`default_nettype none
module min_heap_priority_queue_core
   import mhpq_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   mhpq_req_if.sink   req_ch,
   mhpq_rsp_if.source rsp_ch
);
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  bidx_ff, bidx_in;
   logic              bsel_ff, bsel_in;
   entry_type         mov_ff, mov_in;
   entry_type         best_ff, best_in;
   logic signed [KEY_W-1:0] min_ff, min_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [NRES_W-1:0] n_ff, n_in;
   logic [NRES_W-1:0] j_ff, j_in;
   status_type        st_ff, st_in;

   logic              h_we, h_re, b_we, b_re;
   logic [IDX_W-1:0]  h_waddr, h_raddr;
   entry_type         h_wdata, h_rdata, b_wdata, b_rdata;
   logic [BUF_AW-1:0] b_waddr, b_raddr;

   logic [IDX_W:0]    lchild;
   logic [IDX_W+1:0]  rchild;
   logic [IDX_W-1:0]  parent;
   logic [CMP_W-1:0]  idx_ext, cnt_ext;
   logic              accept;

   mhpq_ram #(.DEPTH(CAPACITY), .WIDTH(ENTRY_W)) u_heap (
      .clock(clock), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
   );

   mhpq_ram #(.DEPTH(MAX_RES), .WIDTH(ENTRY_W)) u_rbuf (
      .clock(clock), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
      .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
   );

   assign lchild  = {pos_ff, 1'b1};
   assign rchild  = {1'b0, lchild} + (IDX_W+2)'(1);
   assign parent  = IDX_W'((pos_ff - IDX_W'(1)) >> 1);
   assign idx_ext = CMP_W'(req_ch.index);
   assign cnt_ext = CMP_W'(cnt_ff);
   assign accept  = req_ch.valid && req_ch.ready;

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = (state_ff == S_DR_OUT);
   assign rsp_ch.key_res   = b_rdata.key;
   assign rsp_ch.value_res = b_rdata.value;
   assign rsp_ch.status    = st_ff;
   assign rsp_ch.last      = (j_ff == n_ff - NRES_W'(1));
   assign rsp_ch.count     = 7'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      pos_ff  <= pos_in;
      bidx_ff <= bidx_in;
      bsel_ff <= bsel_in;
      mov_ff  <= mov_in;
      best_ff <= best_in;
      min_ff  <= min_in;
      key_ff  <= key_in;
      i_ff    <= i_in;
      n_ff    <= n_in;
      j_ff    <= j_in;
      st_ff   <= st_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      bidx_in  = bidx_ff;
      bsel_in  = bsel_ff;
      mov_in   = mov_ff;
      best_in  = best_ff;
      min_in   = min_ff;
      key_in   = key_ff;
      i_in     = i_ff;
      n_in     = n_ff;
      j_in     = j_ff;
      st_in    = st_ff;
      h_we     = 1'b0;
      h_waddr  = pos_ff;
      h_wdata  = mov_ff;
      h_re     = 1'b0;
      h_raddr  = '0;
      b_we     = 1'b0;
      b_waddr  = n_ff[BUF_AW-1:0];
      b_wdata  = '0;
      b_re     = 1'b0;
      b_raddr  = j_ff[BUF_AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               n_in   = '0;
               j_in   = '0;
               st_in  = ST_OK;
               key_in = req_ch.key;
               case (op_type'(req_ch.op))
                  OP_INSERT: begin
                     if (cnt_ff == CNT_W'(CAPACITY)) begin
                        st_in    = ST_FULL;
                        b_we     = 1'b1;
                        b_waddr  = '0;
                        n_in     = NRES_W'(1);
                        state_in = S_DR_RD;
                     end else begin
                        mov_in   = '{key: req_ch.key, value: req_ch.value};
                        pos_in   = cnt_ff[IDX_W-1:0];
                        cnt_in   = cnt_ff + CNT_W'(1);
                        b_we     = 1'b1;
                        b_waddr  = '0;
                        b_wdata  = '{key: req_ch.key, value: req_ch.value};
                        n_in     = NRES_W'(1);
                        state_in = S_SU_RD;
                     end
                  end
                  default: begin
                     if (cnt_ff == '0) begin
                        st_in    = ST_EMPTY;
                        b_we     = 1'b1;
                        b_waddr  = '0;
                        n_in     = NRES_W'(1);
                        state_in = S_DR_RD;
                     end else if (op_type'(req_ch.op) == OP_EXTRACT) begin
                        h_re     = 1'b1;
                        state_in = S_EX_MIN;
                     end else if (op_type'(req_ch.op) == OP_LIST) begin
                        h_re     = 1'b1;
                        state_in = S_LS_MIN;
                     end else if (idx_ext >= cnt_ext) begin
                        st_in    = ST_RANGE;
                        b_we     = 1'b1;
                        b_waddr  = '0;
                        n_in     = NRES_W'(1);
                        state_in = S_DR_RD;
                     end else begin
                        pos_in   = idx_ext[IDX_W-1:0];
                        h_re     = 1'b1;
                        h_raddr  = idx_ext[IDX_W-1:0];
                        state_in = S_SK_VAL;
                     end
                  end
               endcase
            end
         end
         S_SK_VAL: begin
            mov_in   = '{key: key_ff, value: h_rdata.value};
            b_we     = 1'b1;
            b_wdata  = '{key: key_ff, value: h_rdata.value};
            n_in     = NRES_W'(1);
            state_in = S_SU_RD;
         end
         S_SU_RD: begin
            if (pos_ff == '0) begin
               h_we     = 1'b1;
               state_in = S_DR_RD;
            end else begin
               h_re     = 1'b1;
               h_raddr  = parent;
               state_in = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            h_we = 1'b1;
            if (mov_ff.key < h_rdata.key) begin
               h_wdata  = h_rdata;
               pos_in   = parent;
               state_in = S_SU_RD;
            end else begin
               state_in = S_DR_RD;
            end
         end
         S_EX_MIN: begin
            min_in   = h_rdata.key;
            state_in = S_EX_CHK;
         end
         S_EX_CHK: begin
            if (cnt_ff != '0 && n_ff != NRES_W'(MAX_RES) && h_rdata.key == min_ff) begin
               b_we     = 1'b1;
               b_wdata  = h_rdata;
               n_in     = n_ff + NRES_W'(1);
               cnt_in   = cnt_ff - CNT_W'(1);
               h_re     = 1'b1;
               h_raddr  = IDX_W'(cnt_ff - CNT_W'(1));
               state_in = S_EX_LAST;
            end else begin
               state_in = S_DR_RD;
            end
         end
         S_EX_LAST: begin
            mov_in   = h_rdata;
            pos_in   = '0;
            state_in = S_SD_RL;
         end
         S_EX_RD: begin
            h_re     = 1'b1;
            state_in = S_EX_CHK;
         end
         S_SD_RL: begin
            if (lchild >= cnt_ff) begin
               h_we     = 1'b1;
               state_in = S_EX_RD;
            end else begin
               h_re     = 1'b1;
               h_raddr  = lchild[IDX_W-1:0];
               state_in = S_SD_L;
            end
         end
         S_SD_L: begin
            if (h_rdata.key < mov_ff.key) begin
               best_in = h_rdata;
               bsel_in = 1'b1;
               bidx_in = lchild[IDX_W-1:0];
            end else begin
               best_in = mov_ff;
               bsel_in = 1'b0;
            end
            if (rchild < {1'b0, cnt_ff}) begin
               h_re     = 1'b1;
               h_raddr  = rchild[IDX_W-1:0];
               state_in = S_SD_R;
            end else begin
               state_in = S_SD_DEC;
            end
         end
         S_SD_R: begin
            if (h_rdata.key < best_ff.key) begin
               best_in = h_rdata;
               bsel_in = 1'b1;
               bidx_in = rchild[IDX_W-1:0];
            end
            state_in = S_SD_DEC;
         end
         S_SD_DEC: begin
            h_we = 1'b1;
            if (bsel_ff) begin
               h_wdata  = best_ff;
               pos_in   = bidx_ff;
               state_in = S_SD_RL;
            end else begin
               state_in = S_EX_RD;
            end
         end
         S_LS_MIN: begin
            min_in   = h_rdata.key;
            i_in     = '0;
            state_in = S_LS_RD;
         end
         S_LS_RD: begin
            if (i_ff == cnt_ff || n_ff == NRES_W'(MAX_RES)) begin
               state_in = S_DR_RD;
            end else begin
               h_re     = 1'b1;
               h_raddr  = i_ff[IDX_W-1:0];
               state_in = S_LS_CMP;
            end
         end
         S_LS_CMP: begin
            if (h_rdata.key == min_ff) begin
               b_we    = 1'b1;
               b_wdata = h_rdata;
               n_in    = n_ff + NRES_W'(1);
            end
            i_in     = i_ff + CNT_W'(1);
            state_in = S_LS_RD;
         end
         S_DR_RD: begin
            b_re     = 1'b1;
            state_in = S_DR_OUT;
         end
         S_DR_OUT: begin
            if (rsp_ch.ready) begin
               if (rsp_ch.last) begin
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + NRES_W'(1);
                  state_in = S_DR_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && st_ff != ST_OK |-> rsp_ch.last && rsp_ch.key_res == '0)
      else $error("error response not a single zero word");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("request taken while busy");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> n_ff != '0 && j_ff < n_ff)
      else $error("drain index outside result buffer");
endmodule
`default_nettype wire
